// ===== hw/rtl/rdsp_pkg.sv =====
// Shared constants, codes and types of the delta script parser.
`default_nettype none
package rdsp_pkg;

  // Line number width and the widths derived from it
  localparam int LINE_BITS = 32;
  localparam int POS_W     = LINE_BITS + 1;
  localparam int ADJ_W     = LINE_BITS + 2;
  localparam int SUM_W     = LINE_BITS + 3;
  localparam int ACC_W     = LINE_BITS + 4;

  localparam logic [POS_W-1:0] POS_ONE = 1;

  // Result kinds
  localparam logic [2:0] K_ADD = 3'd0;
  localparam logic [2:0] K_DEL = 3'd1;
  localparam logic [2:0] K_PAY = 3'd2;
  localparam logic [2:0] K_END = 3'd3;
  localparam logic [2:0] K_ERR = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_CORRUPT   = 3'd1;
  localparam logic [2:0] ERR_BACK_ADD  = 3'd2;
  localparam logic [2:0] ERR_BACK_DEL  = 3'd3;
  localparam logic [2:0] ERR_NO_OPEN   = 3'd4;
  localparam logic [2:0] ERR_TRUNCATED = 3'd5;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd6;

  // Byte values
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Outcome of checking a finished command line
  typedef struct packed {
    logic [2:0]       err;
    logic [POS_W-1:0] pos;
    logic [ADJ_W-1:0] adjust;
    logic [POS_W-1:0] earliest;
    logic [POS_W-1:0] delete_end;
  } rdsp_cmd_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rdsp_digit_acc.sv =====
// Decimal accumulator step: value times ten plus one digit, with overflow flag.
`default_nettype none
module rdsp_digit_acc (
  input  logic [rdsp_pkg::LINE_BITS-1:0] acc,
  input  logic [3:0]                     digit,
  output logic [rdsp_pkg::LINE_BITS-1:0] value,
  output logic                           overflow
);

  logic [rdsp_pkg::ACC_W-1:0] acc_ext;
  logic [rdsp_pkg::ACC_W-1:0] prod;

  // Multiply by ten as two shifts and add the digit
  assign acc_ext  = {4'b0000, acc};
  assign prod     = (acc_ext << 3) + (acc_ext << 1)
                  + {{(rdsp_pkg::ACC_W-4){1'b0}}, digit};
  assign value    = prod[rdsp_pkg::LINE_BITS-1:0];
  assign overflow = |prod[rdsp_pkg::ACC_W-1:rdsp_pkg::LINE_BITS];

endmodule
`default_nettype wire

// ===== hw/rtl/rdsp_cmd_check.sv =====
// Checks a finished edit command and works out its position and new adjust.
`default_nettype none
module rdsp_cmd_check (
  input  logic                           letter_ok,
  input  logic                           is_add,
  input  logic [rdsp_pkg::LINE_BITS-1:0] first,
  input  logic [rdsp_pkg::LINE_BITS-1:0] count,
  input  logic [rdsp_pkg::POS_W-1:0]     earliest,
  input  logic [rdsp_pkg::POS_W-1:0]     delete_end,
  input  logic [rdsp_pkg::ADJ_W-1:0]     adjust,
  output rdsp_pkg::rdsp_cmd_res_t        res
);

  logic [rdsp_pkg::POS_W-1:0] first_ext;
  logic [rdsp_pkg::POS_W-1:0] count_ext;
  logic [rdsp_pkg::POS_W-1:0] base;
  logic [rdsp_pkg::SUM_W-1:0] adj_ext;
  logic [rdsp_pkg::SUM_W-1:0] cnt_sum_ext;
  logic [rdsp_pkg::SUM_W-1:0] pos_sum;
  logic [rdsp_pkg::SUM_W-1:0] adj_sum;
  logic [2:0]                 pos_top;
  logic                       corrupt;
  logic                       backward;
  logic                       pos_ok;
  logic                       adj_ok;

  assign first_ext   = {1'b0, first};
  assign count_ext   = {1'b0, count};
  assign adj_ext     = {adjust[rdsp_pkg::ADJ_W-1], adjust};
  assign cnt_sum_ext = {3'b000, count};

  // Deletes address the line before the first one
  assign base = is_add ? first_ext : first_ext - rdsp_pkg::POS_ONE;

  // Position must fit the signed position range
  assign pos_sum = {{2{base[rdsp_pkg::POS_W-1]}}, base} + adj_ext;
  assign pos_top = pos_sum[rdsp_pkg::SUM_W-1:rdsp_pkg::POS_W-1];
  assign pos_ok  = (&pos_top) | ~(|pos_top);

  // Adjust must stay inside its signed range
  assign adj_sum = is_add ? adj_ext + cnt_sum_ext : adj_ext - cnt_sum_ext;
  assign adj_ok  = adj_sum[rdsp_pkg::SUM_W-1] == adj_sum[rdsp_pkg::SUM_W-2];

  assign corrupt  = !letter_ok || (count == '0);
  assign backward = is_add ? (first_ext < earliest)
                           : ((first_ext < earliest) || (first_ext < delete_end));

  // Pick the first failing check in order
  always_comb begin
    if (corrupt) begin
      res.err = rdsp_pkg::ERR_CORRUPT;
    end else if (backward) begin
      res.err = is_add ? rdsp_pkg::ERR_BACK_ADD : rdsp_pkg::ERR_BACK_DEL;
    end else if (!pos_ok || !adj_ok) begin
      res.err = rdsp_pkg::ERR_OVERFLOW;
    end else begin
      res.err = rdsp_pkg::ERR_NONE;
    end
    res.pos        = pos_sum[rdsp_pkg::POS_W-1:0];
    res.adjust     = adj_sum[rdsp_pkg::ADJ_W-1:0];
    res.earliest   = is_add ? first_ext + rdsp_pkg::POS_ONE : first_ext;
    res.delete_end = first_ext + count_ext;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rcs_delta_script_parser.sv =====
// Top level of the quoted delta text edit script parser.
//
// Bytes of one at-sign quoted delta text arrive on the input channel
// (in_valid/in_stall, text_byte, start_of_text); start_of_text marks the first
// byte of a new text and clears all parser state before that byte is taken.
// Each byte gives at most one result on the output channel (out_valid,
// out_stall): an add or delete command with its adjusted position and count,
// a payload byte, end of text, or an error with its code.
// The text_mode register (cfg_write, cfg_data) selects script or whole-text
// parsing, sampled at the opening at sign; write it only while idle (unenforced).
// Each result is registered in the cycle after its request. One byte is taken
// every cycle unless stalled; the limit is the single state update per byte,
// whose longest path is the times-ten digit step and the command range checks.
// A stalled result holds in the output register; new requests are held off
// only while that register is full and stalled.
// Synchronous reset clears the parser to wait for the opening at sign,
// sets text_mode to script parsing and empties the output register.
`default_nettype none
module rcs_delta_script_parser (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic                                  cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            text_byte,
  input  logic                                  start_of_text,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [2:0]                            result_kind,
  output logic signed [rdsp_pkg::POS_W-1:0]     edit_position,
  output logic [rdsp_pkg::LINE_BITS-1:0]        edit_count,
  output logic [7:0]                            payload_byte,
  output logic                                  line_end,
  output logic [2:0]                            error_code
);

  typedef enum logic [10:0] {
    PH_OPEN      = 11'b000_0000_0001,
    PH_CMD       = 11'b000_0000_0010,
    PH_NUM1      = 11'b000_0000_0100,
    PH_SPACES    = 11'b000_0000_1000,
    PH_NUM2      = 11'b000_0001_0000,
    PH_SKIP      = 11'b000_0010_0000,
    PH_PAY_START = 11'b000_0100_0000,
    PH_PAY_MID   = 11'b000_1000_0000,
    PH_TEXT      = 11'b001_0000_0000,
    PH_DONE      = 11'b010_0000_0000,
    PH_ERR       = 11'b100_0000_0000
  } phase_t;

  // Parser state
  logic                           text_mode;
  phase_t                         phase, phase_next, cur_phase;
  logic                           at_pending, at_pending_next, cur_at;
  logic                           command_is_add, command_is_add_next;
  logic                           letter_ok, letter_ok_next;
  logic [rdsp_pkg::LINE_BITS-1:0] first_number, first_number_next, cur_first;
  logic [rdsp_pkg::LINE_BITS-1:0] second_number, second_number_next, cur_second;
  logic [rdsp_pkg::POS_W-1:0]     earliest_next_line, earliest_next_line_next;
  logic [rdsp_pkg::POS_W-1:0]     cur_earliest;
  logic [rdsp_pkg::POS_W-1:0]     delete_end_line, delete_end_line_next, cur_del_end;
  logic [rdsp_pkg::ADJ_W-1:0]     line_adjust, line_adjust_next, cur_adjust;
  logic [rdsp_pkg::LINE_BITS-1:0] payload_lines_left, payload_lines_left_next;
  logic [rdsp_pkg::LINE_BITS-1:0] cur_left, left_dec;
  logic                           cur_is_add, cur_letter_ok;

  // Result of this request
  logic                           res_valid;
  logic [2:0]                     res_kind;
  logic [rdsp_pkg::POS_W-1:0]     res_pos;
  logic [rdsp_pkg::LINE_BITS-1:0] res_count;
  logic [7:0]                     res_byte;
  logic                           res_eol;
  logic [2:0]                     res_err;

  logic                           accept;
  logic                           is_digit;
  logic                           is_nl;
  logic                           take;
  logic                           tail;
  logic [rdsp_pkg::LINE_BITS-1:0] acc_in, acc_value;
  logic                           acc_overflow;
  rdsp_pkg::rdsp_cmd_res_t        cmd_res;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Start of text clears the state before the byte is taken
  assign cur_phase     = start_of_text ? PH_OPEN : phase;
  assign cur_at        = start_of_text ? 1'b0 : at_pending;
  assign cur_is_add    = start_of_text ? 1'b0 : command_is_add;
  assign cur_letter_ok = start_of_text ? 1'b0 : letter_ok;
  assign cur_first     = start_of_text ? '0 : first_number;
  assign cur_second    = start_of_text ? '0 : second_number;
  assign cur_earliest  = start_of_text ? '0 : earliest_next_line;
  assign cur_del_end   = start_of_text ? '0 : delete_end_line;
  assign cur_adjust    = start_of_text ? '0 : line_adjust;
  assign cur_left      = start_of_text ? '0 : payload_lines_left;
  assign left_dec      = cur_left - {{(rdsp_pkg::LINE_BITS-1){1'b0}}, 1'b1};

  assign is_digit = (text_byte >= rdsp_pkg::CH_ZERO) && (text_byte <= rdsp_pkg::CH_NINE);
  assign is_nl    = text_byte == rdsp_pkg::CH_NL;

  // Shared digit step for both numbers
  assign acc_in = (cur_phase == PH_NUM1) ? cur_first : cur_second;

  rdsp_digit_acc u_digit_acc (
    .acc      (acc_in),
    .digit    (text_byte[3:0]),
    .value    (acc_value),
    .overflow (acc_overflow)
  );

  rdsp_cmd_check u_cmd_check (
    .letter_ok  (cur_letter_ok),
    .is_add     (cur_is_add),
    .first      (cur_first),
    .count      (cur_second),
    .earliest   (cur_earliest),
    .delete_end (cur_del_end),
    .adjust     (cur_adjust),
    .res        (cmd_res)
  );

  // Work out next state and result for one byte
  always_comb begin
    phase_next              = cur_phase;
    at_pending_next         = cur_at;
    command_is_add_next     = cur_is_add;
    letter_ok_next          = cur_letter_ok;
    first_number_next       = cur_first;
    second_number_next      = cur_second;
    earliest_next_line_next = cur_earliest;
    delete_end_line_next    = cur_del_end;
    line_adjust_next        = cur_adjust;
    payload_lines_left_next = cur_left;
    res_valid               = 1'b0;
    res_kind                = rdsp_pkg::K_ADD;
    res_pos                 = '0;
    res_count               = '0;
    res_byte                = '0;
    res_eol                 = 1'b0;
    res_err                 = rdsp_pkg::ERR_NONE;
    take                    = 1'b0;
    tail                    = 1'b0;

    case (cur_phase)
      PH_DONE, PH_ERR: begin
      end
      PH_OPEN: begin
        if (text_byte != rdsp_pkg::CH_AT) begin
          phase_next = PH_ERR;
          res_valid  = 1'b1;
          res_kind   = rdsp_pkg::K_ERR;
          res_err    = rdsp_pkg::ERR_NO_OPEN;
        end else begin
          phase_next = text_mode ? PH_TEXT : PH_CMD;
        end
      end
      default: begin
        // Unquote: a doubled at sign is one byte, any other byte ends the text
        if (cur_at) begin
          at_pending_next = 1'b0;
          if (text_byte != rdsp_pkg::CH_AT) begin
            res_valid = 1'b1;
            if (cur_phase == PH_CMD || cur_phase == PH_TEXT ||
                (cur_phase == PH_PAY_MID &&
                 cur_left == {{(rdsp_pkg::LINE_BITS-1){1'b0}}, 1'b1})) begin
              phase_next = PH_DONE;
              res_kind   = rdsp_pkg::K_END;
            end else begin
              phase_next = PH_ERR;
              res_kind   = rdsp_pkg::K_ERR;
              res_err    = rdsp_pkg::ERR_TRUNCATED;
            end
          end else begin
            take = 1'b1;
          end
        end else if (text_byte == rdsp_pkg::CH_AT) begin
          at_pending_next = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
    endcase

    // Parse the unquoted byte
    if (take) begin
      case (cur_phase)
        PH_TEXT: begin
          res_valid = 1'b1;
          res_kind  = rdsp_pkg::K_PAY;
          res_byte  = text_byte;
          res_eol   = is_nl;
        end
        PH_PAY_START, PH_PAY_MID: begin
          if (is_nl) begin
            payload_lines_left_next = left_dec;
            phase_next = (left_dec == '0) ? PH_CMD : PH_PAY_START;
          end else begin
            phase_next = PH_PAY_MID;
          end
          res_valid = 1'b1;
          res_kind  = rdsp_pkg::K_PAY;
          res_byte  = text_byte;
          res_eol   = is_nl;
        end
        PH_CMD: begin
          command_is_add_next = text_byte == rdsp_pkg::CH_A;
          letter_ok_next      = (text_byte == rdsp_pkg::CH_A) ||
                                (text_byte == rdsp_pkg::CH_D);
          first_number_next   = '0;
          second_number_next  = '0;
          phase_next          = PH_NUM1;
        end
        PH_NUM1: begin
          if (is_digit) begin
            first_number_next = acc_value;
          end else if (text_byte == rdsp_pkg::CH_SPACE) begin
            phase_next = PH_SPACES;
          end else begin
            tail = 1'b1;
          end
        end
        PH_SPACES: begin
          if (is_digit) begin
            phase_next         = PH_NUM2;
            second_number_next = acc_value;
          end else if (text_byte != rdsp_pkg::CH_SPACE) begin
            tail = 1'b1;
          end
        end
        PH_NUM2: begin
          if (is_digit) begin
            second_number_next = acc_value;
          end else begin
            tail = 1'b1;
          end
        end
        PH_SKIP: begin
          tail = 1'b1;
        end
        default: begin
        end
      endcase

      // Drop to error when a number outgrows its width
      if (is_digit && acc_overflow &&
          (cur_phase == PH_NUM1 || cur_phase == PH_SPACES || cur_phase == PH_NUM2)) begin
        phase_next = PH_ERR;
        res_valid  = 1'b1;
        res_kind   = rdsp_pkg::K_ERR;
        res_err    = rdsp_pkg::ERR_OVERFLOW;
      end
    end

    // End of a command line: check it and emit it
    if (tail) begin
      if (!is_nl) begin
        phase_next = PH_SKIP;
      end else if (cmd_res.err != rdsp_pkg::ERR_NONE) begin
        phase_next = PH_ERR;
        res_valid  = 1'b1;
        res_kind   = rdsp_pkg::K_ERR;
        res_err    = cmd_res.err;
      end else begin
        res_valid               = 1'b1;
        res_pos                 = cmd_res.pos;
        res_count               = cur_second;
        line_adjust_next        = cmd_res.adjust;
        earliest_next_line_next = cmd_res.earliest;
        if (cur_is_add) begin
          res_kind                = rdsp_pkg::K_ADD;
          payload_lines_left_next = cur_second;
          phase_next              = PH_PAY_START;
        end else begin
          res_kind             = rdsp_pkg::K_DEL;
          delete_end_line_next = cmd_res.delete_end;
          phase_next           = PH_CMD;
        end
      end
    end
  end

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_mode <= 1'b0;
    end else if (cfg_write) begin
      text_mode <= cfg_data;
    end
  end

  // Advance parser state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_OPEN;
      at_pending         <= 1'b0;
      command_is_add     <= 1'b0;
      letter_ok          <= 1'b0;
      first_number       <= '0;
      second_number      <= '0;
      earliest_next_line <= '0;
      delete_end_line    <= '0;
      line_adjust        <= '0;
      payload_lines_left <= '0;
    end else if (accept) begin
      phase              <= phase_next;
      at_pending         <= at_pending_next;
      command_is_add     <= command_is_add_next;
      letter_ok          <= letter_ok_next;
      first_number       <= first_number_next;
      second_number      <= second_number_next;
      earliest_next_line <= earliest_next_line_next;
      delete_end_line    <= delete_end_line_next;
      line_adjust        <= line_adjust_next;
      payload_lines_left <= payload_lines_left_next;
    end
  end

  // Output register valid: load on a request, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      result_kind   <= res_kind;
      edit_position <= res_pos;
      edit_count    <= res_count;
      payload_byte  <= res_byte;
      line_end      <= res_eol;
      error_code    <= res_err;
    end
  end

  // An error result leaves the parser in its error state
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == rdsp_pkg::K_ERR) |-> (phase == PH_ERR))
    else $error("error result without parser in error state");

  // An end of text result leaves the parser done
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == rdsp_pkg::K_END) |-> (phase == PH_DONE))
    else $error("end of text result without parser done");

  // A command result always carries a nonzero count and no error
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_kind == rdsp_pkg::K_ADD || result_kind == rdsp_pkg::K_DEL))
      |-> (edit_count != '0 && error_code == rdsp_pkg::ERR_NONE))
    else $error("command result with zero count or error code");

endmodule
`default_nettype wire

// ===== sim/rcs_delta_script_parser_tb.sv =====
// Self-checking testbench of the delta script parser: byte streams, predictor and scoreboard.
`default_nettype none
module rcs_delta_script_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT = 500000;
  localparam int          SETTLE      = 8;
  localparam int          MAX_WAIT    = 19;

  // Line number bounds, held as 64-bit integers
  localparam longint unsigned LINE_MAX = (64'd1 << rdsp_pkg::LINE_BITS) - 64'd1;
  localparam longint          POS_HI   = longint'(LINE_MAX);
  localparam longint          POS_LO   = -POS_HI - 1;
  localparam longint          ADJ_HI   =
    longint'((64'd1 << (rdsp_pkg::LINE_BITS + 1)) - 64'd1);
  localparam longint          ADJ_LO   = -ADJ_HI - 1;

  typedef struct packed {
    logic [2:0]                     kind;
    logic [rdsp_pkg::POS_W-1:0]     pos;
    logic [rdsp_pkg::LINE_BITS-1:0] count;
    logic [7:0]                     data;
    logic                           eol;
    logic [2:0]                     code;
  } parse_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       sot;
  } text_req_t;

  typedef enum int {
    ST_OPEN, ST_LETTER, ST_FIRST, ST_SPACES, ST_COUNT, ST_SKIP,
    ST_LINE_START, ST_LINE_MID, ST_TEXT, ST_DONE, ST_FAILED
  } parse_state_t;

  // Parser predictor plus the queue of results it has promised
  class script_scoreboard;
    bit              text_mode;
    parse_state_t    state;
    bit              at_seen;
    bit              is_add;
    bit              letter_good;
    longint unsigned first_num;
    longint unsigned count_num;
    longint unsigned earliest;
    longint unsigned del_end;
    longint unsigned lines_left;
    longint          adjust;
    parse_result_t   expected_results[$];
    int unsigned     failures;

    function new();
      text_mode = 1'b0;
      failures  = 0;
      clear();
    endfunction

    function void clear();
      state       = ST_OPEN;
      at_seen     = 1'b0;
      is_add      = 1'b0;
      letter_good = 1'b0;
      first_num   = 0;
      count_num   = 0;
      earliest    = 0;
      del_end     = 0;
      lines_left  = 0;
      adjust      = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void push(logic [2:0] k, longint p, longint unsigned c, logic [7:0] d,
                       logic e, logic [2:0] code);
      parse_result_t r;
      r.kind  = k;
      r.pos   = p[rdsp_pkg::POS_W-1:0];
      r.count = c[rdsp_pkg::LINE_BITS-1:0];
      r.data  = d;
      r.eol   = e;
      r.code  = code;
      expected_results.push_back(r);
    endfunction

    function void fail(logic [2:0] code);
      state = ST_FAILED;
      push(rdsp_pkg::K_ERR, 0, 0, 8'h00, 1'b0, code);
    endfunction

    // Append a decimal digit; report overflow of the line width
    function bit add_digit(inout longint unsigned acc, input logic [7:0] b);
      longint unsigned dv;
      dv = 64'(b) - 64'(rdsp_pkg::CH_ZERO);
      if (acc > (LINE_MAX - dv) / 10) return 1'b0;
      acc = acc * 10 + dv;
      return 1'b1;
    endfunction

    function void close_text();
      if (state == ST_LETTER || state == ST_TEXT ||
          (state == ST_LINE_MID && lines_left == 1)) begin
        state = ST_DONE;
        push(rdsp_pkg::K_END, 0, 0, 8'h00, 1'b0, rdsp_pkg::ERR_NONE);
      end else begin
        fail(rdsp_pkg::ERR_TRUNCATED);
      end
    endfunction

    // Check a finished command line and work out its shifted position
    function void close_command();
      longint v;
      longint p;
      if (!letter_good || count_num == 0) begin
        fail(rdsp_pkg::ERR_CORRUPT);
        return;
      end
      if (is_add) begin
        if (first_num < earliest) begin
          fail(rdsp_pkg::ERR_BACK_ADD);
          return;
        end
        v = longint'(first_num);
      end else begin
        if (first_num < earliest || first_num < del_end) begin
          fail(rdsp_pkg::ERR_BACK_DEL);
          return;
        end
        v = longint'(first_num) - 1;
      end
      if (adjust > POS_HI - v || adjust < POS_LO - v) begin
        fail(rdsp_pkg::ERR_OVERFLOW);
        return;
      end
      p = adjust + v;
      if (is_add) begin
        if (adjust > ADJ_HI - longint'(count_num)) begin
          fail(rdsp_pkg::ERR_OVERFLOW);
          return;
        end
        earliest   = first_num + 1;
        adjust     = adjust + longint'(count_num);
        lines_left = count_num;
        state      = ST_LINE_START;
        push(rdsp_pkg::K_ADD, p, count_num, 8'h00, 1'b0, rdsp_pkg::ERR_NONE);
        return;
      end
      if (adjust < ADJ_LO + longint'(count_num)) begin
        fail(rdsp_pkg::ERR_OVERFLOW);
        return;
      end
      earliest = first_num;
      del_end  = first_num + count_num;
      adjust   = adjust - longint'(count_num);
      state    = ST_LETTER;
      push(rdsp_pkg::K_DEL, p, count_num, 8'h00, 1'b0, rdsp_pkg::ERR_NONE);
    endfunction

    // Advance the command or payload parser by one unescaped byte
    function void take(logic [7:0] b);
      bit digit;
      digit = (b >= rdsp_pkg::CH_ZERO && b <= rdsp_pkg::CH_NINE);
      case (state)
        ST_TEXT: begin
          push(rdsp_pkg::K_PAY, 0, 0, b, b == rdsp_pkg::CH_NL, rdsp_pkg::ERR_NONE);
          return;
        end
        ST_LINE_START, ST_LINE_MID: begin
          if (b == rdsp_pkg::CH_NL) begin
            lines_left = (lines_left - 1) & LINE_MAX;
            state = (lines_left == 0) ? ST_LETTER : ST_LINE_START;
          end else begin
            state = ST_LINE_MID;
          end
          push(rdsp_pkg::K_PAY, 0, 0, b, b == rdsp_pkg::CH_NL, rdsp_pkg::ERR_NONE);
          return;
        end
        ST_LETTER: begin
          is_add      = (b == rdsp_pkg::CH_A);
          letter_good = (b == rdsp_pkg::CH_A || b == rdsp_pkg::CH_D);
          first_num   = 0;
          count_num   = 0;
          state       = ST_FIRST;
          return;
        end
        ST_FIRST: begin
          if (digit) begin
            if (!add_digit(first_num, b)) fail(rdsp_pkg::ERR_OVERFLOW);
            return;
          end
          if (b == rdsp_pkg::CH_SPACE) begin
            state = ST_SPACES;
            return;
          end
        end
        ST_SPACES: begin
          if (b == rdsp_pkg::CH_SPACE) return;
          if (digit) begin
            state = ST_COUNT;
            if (!add_digit(count_num, b)) fail(rdsp_pkg::ERR_OVERFLOW);
            return;
          end
        end
        ST_COUNT: begin
          if (digit) begin
            if (!add_digit(count_num, b)) fail(rdsp_pkg::ERR_OVERFLOW);
            return;
          end
        end
        ST_SKIP: ;
        default: return;
      endcase
      if (b == rdsp_pkg::CH_NL) close_command();
      else state = ST_SKIP;
    endfunction

    // Predict the outcome of one accepted request
    function void note_request(logic [7:0] b, logic sot);
      if (sot) clear();
      if (state == ST_DONE || state == ST_FAILED) return;
      if (state == ST_OPEN) begin
        if (b != rdsp_pkg::CH_AT) fail(rdsp_pkg::ERR_NO_OPEN);
        else state = text_mode ? ST_TEXT : ST_LETTER;
        return;
      end
      if (at_seen) begin
        at_seen = 1'b0;
        if (b != rdsp_pkg::CH_AT) begin
          close_text();
          return;
        end
      end else if (b == rdsp_pkg::CH_AT) begin
        at_seen = 1'b1;
        return;
      end
      take(b);
    endfunction

    function void check_field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
        failures++;
      end
    endfunction

    // Compare a delivered result with the oldest promised one
    function void check_result(parse_result_t got);
      parse_result_t exp;
      if (expected_results.size() == 0) begin
        $error("result_kind: expected no result, got 0x%0h", got.kind);
        failures++;
        return;
      end
      exp = expected_results.pop_front();
      check_field("result_kind", 64'(exp.kind), 64'(got.kind));
      check_field("edit_position", 64'(exp.pos), 64'(got.pos));
      check_field("edit_count", 64'(exp.count), 64'(got.count));
      check_field("payload_byte", 64'(exp.data), 64'(got.data));
      check_field("line_end", 64'(exp.eol), 64'(got.eol));
      check_field("error_code", 64'(exp.code), 64'(got.code));
    endfunction
  endclass

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 cfg_write = 1'b0;
  logic                                 cfg_data = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic [7:0]                           text_byte = 8'h00;
  logic                                 start_of_text = 1'b0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic [2:0]                           result_kind;
  logic signed [rdsp_pkg::POS_W-1:0]    edit_position;
  logic [rdsp_pkg::LINE_BITS-1:0]       edit_count;
  logic [7:0]                           payload_byte;
  logic                                 line_end;
  logic [2:0]                           error_code;

  script_scoreboard sb = new();
  text_req_t        stream_q[$];
  bit               steady = 1'b0;
  int               stall_left = 0;
  int               cycle_count = 0;

  rcs_delta_script_parser dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .text_byte     (text_byte),
    .start_of_text (start_of_text),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .edit_position (edit_position),
    .edit_count    (edit_count),
    .payload_byte  (payload_byte),
    .line_end      (line_end),
    .error_code    (error_code)
  );

  always #4 clk = ~clk;

  // Stream building helpers
  function automatic void put(logic [7:0] b, logic s = 1'b0);
    stream_q.push_back(text_req_t'{data: b, sot: s});
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void put_escaped(logic [7:0] b);
    put(b);
    if (b == rdsp_pkg::CH_AT) put(b);
  endfunction

  function automatic void put_number(longint unsigned v);
    if ($urandom_range(0, 7) == 0) put(rdsp_pkg::CH_ZERO);
    put_str($sformatf("%0d", v));
  endfunction

  function automatic void put_command(logic [7:0] letter, longint unsigned first,
                                      longint unsigned n);
    put(letter);
    put_number(first);
    repeat ($urandom_range(1, 3)) put(rdsp_pkg::CH_SPACE);
    put_number(n);
    put(rdsp_pkg::CH_NL);
  endfunction

  // One payload line of random bytes, newline optional
  function automatic void put_line(bit with_nl);
    logic [7:0] b;
    repeat ($urandom_range(0, 6)) begin
      do b = 8'($urandom_range(0, 255)); while (b == rdsp_pkg::CH_NL);
      put_escaped(b);
    end
    if (with_nl) put(rdsp_pkg::CH_NL);
  endfunction

  // Closing at sign followed by any byte but another at sign
  function automatic void put_close();
    logic [7:0] b;
    put(rdsp_pkg::CH_AT);
    do b = 8'($urandom_range(0, 255)); while (b == rdsp_pkg::CH_AT);
    put(b);
  endfunction

  function automatic logic [7:0] pick_letter();
    return $urandom_range(0, 1) ? rdsp_pkg::CH_A : rdsp_pkg::CH_D;
  endfunction

  // A command line that breaks one rule of the script
  function automatic void put_broken(longint unsigned early);
    case ($urandom_range(0, 7))
      0: begin
        put(8'($urandom_range(0, 255)));
        put_number($urandom_range(0, 9));
        put(rdsp_pkg::CH_SPACE);
        put_number($urandom_range(1, 3));
        put(rdsp_pkg::CH_NL);
      end
      1: put_command(pick_letter(), early, 0);
      2: begin
        if (early > 0) put_command(pick_letter(), early - 1, 1);
        else put_command(rdsp_pkg::CH_D, 0, 1);
      end
      3: begin
        put(pick_letter());
        if ($urandom_range(0, 1)) begin
          put_number(LINE_MAX + 1 + $urandom_range(0, 9));
        end else begin
          put_number(early);
          put(rdsp_pkg::CH_SPACE);
          put_number(LINE_MAX + 1 + $urandom_range(0, 9));
        end
        put(rdsp_pkg::CH_NL);
      end
      4: begin
        put(rdsp_pkg::CH_A);
        put_number(early);
        put(8'($urandom_range(0, 255)));
        put_number(1);
        put(rdsp_pkg::CH_NL);
      end
      5: begin
        put(rdsp_pkg::CH_D);
        put_number(early);
        put(rdsp_pkg::CH_NL);
      end
      6: begin
        put(rdsp_pkg::CH_A);
        put_number(early);
      end
      default: begin
        put_command(rdsp_pkg::CH_A, early, LINE_MAX - $urandom_range(0, 1));
        put_line(1'b1);
      end
    endcase
  endfunction

  // A mostly well-formed edit script with random content
  function automatic void gen_script_text();
    longint unsigned early = 0;
    longint unsigned dend = 0;
    longint unsigned first;
    longint unsigned lo;
    longint unsigned n;
    int ncmd;
    int pick;
    put(rdsp_pkg::CH_AT, 1'b1);
    ncmd = $urandom_range(0, 6);
    for (int i = 0; i < ncmd; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        first = early + $urandom_range(0, 4);
        if ($urandom_range(0, 15) == 0) first = LINE_MAX - $urandom_range(0, 2);
        n = $urandom_range(1, 3);
        put_command(rdsp_pkg::CH_A, first, n);
        for (int j = 0; j < n; j++) begin
          // leave the last line of the text open now and then
          put_line(!(i == ncmd - 1 && j == n - 1 && $urandom_range(0, 2) == 0));
        end
        early = first + 1;
      end else if (pick < 17) begin
        lo = (early > dend) ? early : dend;
        first = lo + $urandom_range(0, 4);
        n = $urandom_range(1, 5);
        if ($urandom_range(0, 15) == 0) n = LINE_MAX - $urandom_range(0, 1);
        put_command(rdsp_pkg::CH_D, first, n);
        early = first;
        dend = first + n;
      end else begin
        put_broken(early);
        break;
      end
    end
    put_close();
    if ($urandom_range(0, 3) == 0) put(8'($urandom_range(0, 255)));
  endfunction

  function automatic void gen_plain_text();
    put(rdsp_pkg::CH_AT, 1'b1);
    repeat ($urandom_range(0, 30)) put_escaped(8'($urandom_range(0, 255)));
    put_close();
  endfunction

  function automatic void gen_noise();
    repeat ($urandom_range(1, 12)) begin
      put(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
    end
  endfunction

  // Build one phase of stimulus, weighted towards the current mode
  function automatic void gen_phase(bit mode, int budget);
    int pick;
    while (stream_q.size() < budget) begin
      pick = $urandom_range(0, 99);
      if (mode) begin
        if (pick < 80) gen_plain_text();
        else if (pick < 90) gen_script_text();
        else gen_noise();
      end else begin
        if (pick < 85) gen_script_text();
        else if (pick < 93) gen_noise();
        else gen_plain_text();
      end
    end
  endfunction

  // Present one request after a random gap and hold it until taken
  task automatic send_request(text_req_t r);
    int gap;
    if (r.sot) steady = ($urandom_range(0, 3) == 0);
    gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    text_byte     <= r.data;
    start_of_text <= r.sot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r.data, r.sot);
  endtask

  task automatic send_stream();
    while (stream_q.size() > 0) send_request(stream_q.pop_front());
  endtask

  // Drop valid and wait until every promised result has come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(bit v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.text_mode = v;
  endtask

  // Hold results back for a random number of cycles
  initial begin
    forever begin
      @(negedge clk);
      out_stall <= (stall_left > 0);
      if (out_valid === 1'b1 && stall_left > 0) stall_left--;
    end
  end

  // Check every delivered result and draw the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(parse_result_t'{kind: result_kind, pos: edit_position,
                                      count: edit_count, data: payload_byte,
                                      eol: line_end, code: error_code});
      stall_left = steady ? 0 : $urandom_range(0, MAX_WAIT);
    end
  end

  // Abort a run that hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_mode(1'b0);

    // Directed: missing opening, add with escaped at sign, overflow, bad letter
    put(8'hFF, 1'b1);
    put(rdsp_pkg::CH_AT, 1'b1);
    put_str("a0 1\n@@\n@");
    put(8'hFF);
    put(rdsp_pkg::CH_AT, 1'b1);
    put_str("d4294967296");
    put(rdsp_pkg::CH_AT, 1'b1);
    put_str("b1 1\n");
    send_stream();
    drain();

    // Random phases alternating between script and whole-text parsing
    for (int p = 0; p < 6; p++) begin
      write_mode(p[0]);
      gen_phase(p[0], p[0] ? 120 : 330);
      send_stream();
      drain();
    end

    if (sb.failures == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire
